>>> hw/rtl/button_event_detector_defines.svh
// ----------------------------------------------------------------------------
// Button event detector assertion macros
// Concurrent check helpers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_EVENT_DETECTOR_DEFINES_SVH
`define BUTTON_EVENT_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define BED_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("button event detector check failed");
// Next-cycle implication.
`define BED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("button event detector check failed");
`else
`define BED_ASSERT_IMPLIES(lbl, ante, cons)
`define BED_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/bed_pkg.sv
// ----------------------------------------------------------------------------
// Button event detector package
// Shared types and constants for the key lanes and the event merge stage.
// ----------------------------------------------------------------------------
package bed_pkg;

  localparam int unsigned TimerW    = 17;
  localparam int unsigned EdgeW     = 4;
  localparam int unsigned ClicksW   = 3;
  localparam int unsigned KindW     = 3;
  localparam int unsigned KeyOutW   = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned MaskW     = 5;
  localparam int unsigned MsW       = 16;
  localparam int unsigned StepW     = 8;

  typedef enum logic [KindW-1:0] {
    EV_DOWN   = 3'd0,
    EV_UP     = 3'd1,
    EV_LONG   = 3'd2,
    EV_REPEAT = 3'd3,
    EV_MULTI  = 3'd4
  } ev_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REPORT_MASK = 3'd0,
    CFG_LONG_PRESS  = 3'd1,
    CFG_REPEAT      = 3'd2,
    CFG_CLICK_GAP   = 3'd3,
    CFG_TICK_STEP   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [MaskW-1:0] report_mask;
    logic [MsW-1:0]   long_press_ms;
    logic [MsW-1:0]   repeat_ms;
    logic [MsW-1:0]   click_gap_ms;
    logic [StepW-1:0] tick_step_ms;
  } bed_cfg_t;

  typedef struct packed {
    logic               valid;
    ev_kind_e           kind;
    logic [ClicksW-1:0] clicks;
  } bed_event_t;

  typedef struct packed {
    logic buf_busy;
    logic out_busy;
  } bed_merge_status_t;

endpackage

>>> hw/rtl/bed_in_if.sv
// ----------------------------------------------------------------------------
// Scan tick channel
// One beat carries the pressed level of every key.
// ----------------------------------------------------------------------------
interface bed_in_if #(
  parameter int unsigned NUM_KEYS = 3
);
  logic                valid;
  logic                ready;
  logic [NUM_KEYS-1:0] pressed_keys;

  modport source (output valid, output pressed_keys, input ready);
  modport sink   (input valid, input pressed_keys, output ready);
endinterface

>>> hw/rtl/bed_out_if.sv
// ----------------------------------------------------------------------------
// Key event channel
// One beat carries one key event.
// ----------------------------------------------------------------------------
interface bed_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_index;
  logic [2:0] event_kind;
  logic [2:0] click_count;
  logic       last_event;

  modport source (output valid, output key_index, output event_kind,
                  output click_count, output last_event, input ready);
  modport sink   (input valid, input key_index, input event_kind,
                  input click_count, input last_event, output ready);
endinterface

>>> hw/rtl/bed_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// One beat writes one settings register by index.
// ----------------------------------------------------------------------------
interface bed_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/bed_lane.sv
// ----------------------------------------------------------------------------
// Key lane
// Per-key state machine; advances once per accepted scan tick.
// ----------------------------------------------------------------------------
module bed_lane #(
  parameter int unsigned MAX_CLICKS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic                level_i,
  input  bed_pkg::bed_cfg_t   cfg_i,
  output bed_pkg::bed_event_t event_o
);
  import bed_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_DEBOUNCE = 3'd1,
    MODE_HELD     = 3'd2,
    MODE_MULTI    = 3'd3,
    MODE_RELEASE  = 3'd4
  } mode_e;

  localparam logic [EdgeW-1:0] EdgeMax  = {EdgeW{1'b1}};
  localparam logic [EdgeW:0]   EdgeLim  = (EdgeW+1)'(2 * MAX_CLICKS);

  mode_e             mode_q, mode_d;
  logic              prev_q;
  logic [TimerW-1:0] hold_q, hold_d;
  logic [TimerW-1:0] rep_q, rep_d;
  logic [TimerW-1:0] gap_q, gap_d;
  logic [EdgeW-1:0]  edge_q, edge_d;
  logic              fired_q, fired_d;

  logic              same;
  logic [TimerW-1:0] step;
  logic [TimerW-1:0] hold_sum, rep_sum, gap_sum;

  assign same     = (level_i == prev_q);
  assign step     = TimerW'(cfg_i.tick_step_ms);
  assign hold_sum = TimerW'(hold_q + step);
  assign rep_sum  = TimerW'(rep_q + step);
  assign gap_sum  = TimerW'(gap_q + step);

  always_comb begin
    mode_d         = mode_q;
    hold_d         = hold_q;
    rep_d          = rep_q;
    gap_d          = gap_q;
    edge_d         = edge_q;
    fired_d        = fired_q;
    event_o.valid  = 1'b0;
    event_o.kind   = EV_DOWN;
    event_o.clicks = '0;
    case (mode_q)
      MODE_IDLE: begin
        if (level_i) mode_d = MODE_DEBOUNCE;
      end
      MODE_DEBOUNCE: begin
        if (same) begin
          mode_d        = MODE_HELD;
          event_o.valid = 1'b1;
          event_o.kind  = EV_DOWN;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_HELD: begin
        if (same) begin
          if (cfg_i.long_press_ms != '0) begin
            if (hold_q < TimerW'(cfg_i.long_press_ms)) begin
              hold_d = hold_sum;
              if (hold_sum >= TimerW'(cfg_i.long_press_ms)) begin
                fired_d       = 1'b1;
                event_o.valid = 1'b1;
                event_o.kind  = EV_LONG;
              end
            end else if (cfg_i.repeat_ms != '0) begin
              rep_d = rep_sum;
              if (rep_sum >= TimerW'(cfg_i.repeat_ms)) begin
                rep_d         = '0;
                fired_d       = 1'b1;
                event_o.valid = 1'b1;
                event_o.kind  = EV_REPEAT;
              end
            end
          end
        end else if (fired_q) begin
          fired_d = 1'b0;
          mode_d  = MODE_RELEASE;
        end else begin
          mode_d = MODE_MULTI;
        end
      end
      MODE_MULTI: begin
        if (!same) begin
          if (edge_q != EdgeMax) edge_d = EdgeW'(edge_q + 1'b1);
          gap_d = '0;
        end else begin
          gap_d = gap_sum;
          if (gap_sum > TimerW'(cfg_i.click_gap_ms)) begin
            // Runs longer than the click limit end silently.
            if ({1'b0, edge_q} <= EdgeLim) begin
              event_o.valid  = 1'b1;
              event_o.kind   = EV_MULTI;
              event_o.clicks = ClicksW'(edge_q >> 1);
            end
            gap_d  = '0;
            mode_d = MODE_RELEASE;
          end
        end
      end
      MODE_RELEASE: begin
        if (!level_i && same) begin
          event_o.valid = 1'b1;
          event_o.kind  = EV_UP;
          rep_d         = '0;
          hold_d        = '0;
          edge_d        = '0;
          mode_d        = MODE_IDLE;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      prev_q  <= 1'b0;
      hold_q  <= '0;
      rep_q   <= '0;
      gap_q   <= '0;
      edge_q  <= '0;
      fired_q <= 1'b0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      prev_q  <= level_i;
      hold_q  <= hold_d;
      rep_q   <= rep_d;
      gap_q   <= gap_d;
      edge_q  <= edge_d;
      fired_q <= fired_d;
    end
  end

endmodule

>>> hw/rtl/bed_merge.sv
// ----------------------------------------------------------------------------
// Event merge stage
// Captures the lane events of one tick and sends them out one beat each.
// ----------------------------------------------------------------------------
module bed_merge #(
  parameter int unsigned NUM_KEYS = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tick_valid_i,
  output logic                       tick_ready_o,
  input  bed_pkg::bed_event_t        lane_ev_i [NUM_KEYS],
  input  logic [bed_pkg::MaskW-1:0]  report_mask_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bed_pkg::KeyOutW-1:0]  key_index_o,
  output logic [bed_pkg::KindW-1:0]    event_kind_o,
  output logic [bed_pkg::ClicksW-1:0]  click_count_o,
  output logic                       last_event_o,
  output bed_pkg::bed_merge_status_t status_o
);
  import bed_pkg::*;

  localparam int unsigned KeyIdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [NUM_KEYS-1:0] pend_q, pend_d;
  ev_kind_e            kind_q   [NUM_KEYS];
  logic [ClicksW-1:0]  clicks_q [NUM_KEYS];

  logic                out_valid_q;
  logic [KeyOutW-1:0]  key_q;
  logic [KindW-1:0]    kind_out_q;
  logic [ClicksW-1:0]  clicks_out_q;
  logic                last_q;

  logic                sel_any;
  logic [KeyIdxW-1:0]  sel_idx;
  logic [NUM_KEYS-1:0] sel_hot;
  logic [NUM_KEYS-1:0] pend_left;
  logic                load;
  logic                accept;
  logic [NUM_KEYS-1:0] new_pend;

  // Pick the lowest pending key.
  always_comb begin
    sel_any = 1'b0;
    sel_idx = '0;
    sel_hot = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!sel_any && pend_q[k]) begin
        sel_any    = 1'b1;
        sel_idx    = KeyIdxW'(k);
        sel_hot[k] = 1'b1;
      end
    end
  end

  assign load         = sel_any && (!out_valid_q || out_ready_i);
  assign pend_left    = pend_q & ~(load ? sel_hot : '0);
  assign tick_ready_o = (pend_left == '0);
  assign accept       = tick_valid_i && tick_ready_o;

  // Drop events whose kind is masked off.
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      new_pend[k] = lane_ev_i[k].valid && report_mask_i[lane_ev_i[k].kind];
    end
  end

  assign pend_d = accept ? new_pend : pend_left;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        kind_q[k]   <= lane_ev_i[k].kind;
        clicks_q[k] <= lane_ev_i[k].clicks;
      end
    end
    if (load) begin
      key_q        <= KeyOutW'(sel_idx);
      kind_out_q   <= kind_q[sel_idx];
      clicks_out_q <= clicks_q[sel_idx];
      last_q       <= (pend_left == '0);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign key_index_o       = key_q;
  assign event_kind_o      = kind_out_q;
  assign click_count_o     = clicks_out_q;
  assign last_event_o      = last_q;
  assign status_o.buf_busy = (pend_q != '0);
  assign status_o.out_busy = out_valid_q;

endmodule

>>> hw/rtl/button_event_detector.sv
// ----------------------------------------------------------------------------
// Button event detector
// Debounces a bank of keys and reports down, up, long, repeat and multi-click.
// ----------------------------------------------------------------------------
// Usage:
//   tick_i  - one beat per scan tick, pressed_keys bit k high while key k is
//             pressed. All key lanes advance together on the accepted beat.
//   event_o - one beat per reported event, in key order within a tick;
//             last_event marks the final event of its tick. A tick with no
//             enabled event sends nothing.
//   cfg_i   - register writes by index (mask, long press, repeat, click gap,
//             tick step). Always ready; write only while the block is idle.
// Path: the first event of a tick passes the event buffer, then the output register.
// Throughput: a tick is taken every cycle while ticks yield at most one event and
//   event_o is ready; a tick with more events holds the next tick off while the
//   single output register drains the event buffer, one beat per ready cycle.
// Reset: every key goes idle and released, timers clear, registers return to
//   mask 1, long 1000, repeat 100, gap 300, step 10.
// Stall: the output register holds its beat; one tick's events wait in the
//   buffer behind it, and tick_i drops ready until that buffer can empty.
// ----------------------------------------------------------------------------
`include "button_event_detector_defines.svh"

module button_event_detector #(
  parameter int unsigned NUM_KEYS   = 3,
  parameter int unsigned MAX_CLICKS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bed_in_if.sink       tick_i,
  bed_out_if.source    event_o,
  bed_cfg_if.sink      cfg_i
);
  import bed_pkg::*;

  bed_cfg_t          cfg_q;
  bed_event_t        lane_ev [NUM_KEYS];
  bed_merge_status_t merge_st;
  logic              tick_ready;
  logic              tick_take;

  // Settings registers: shared by every lane.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.report_mask   <= MaskW'(1);
      cfg_q.long_press_ms <= MsW'(1000);
      cfg_q.repeat_ms     <= MsW'(100);
      cfg_q.click_gap_ms  <= MsW'(300);
      cfg_q.tick_step_ms  <= StepW'(10);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_REPORT_MASK: cfg_q.report_mask   <= cfg_i.data[MaskW-1:0];
        CFG_LONG_PRESS:  cfg_q.long_press_ms <= cfg_i.data[MsW-1:0];
        CFG_REPEAT:      cfg_q.repeat_ms     <= cfg_i.data[MsW-1:0];
        CFG_CLICK_GAP:   cfg_q.click_gap_ms  <= cfg_i.data[MsW-1:0];
        CFG_TICK_STEP:   cfg_q.tick_step_ms  <= cfg_i.data[StepW-1:0];
        default: begin
          // Unknown index: drop the write.
        end
      endcase
    end
  end

  assign tick_i.ready = tick_ready;
  assign tick_take    = tick_i.valid && tick_ready;

  // One lane per key; each owns its state and advances on the tick beat.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    bed_lane #(
      .MAX_CLICKS (MAX_CLICKS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (tick_take),
      .level_i   (tick_i.pressed_keys[k]),
      .cfg_i     (cfg_q),
      .event_o   (lane_ev[k])
    );
  end

  // Mask, buffer and serialize the lane events of one tick.
  bed_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_valid_i  (tick_i.valid),
    .tick_ready_o  (tick_ready),
    .lane_ev_i     (lane_ev),
    .report_mask_i (cfg_q.report_mask),
    .out_valid_o   (event_o.valid),
    .out_ready_i   (event_o.ready),
    .key_index_o   (event_o.key_index),
    .event_kind_o  (event_o.event_kind),
    .click_count_o (event_o.click_count),
    .last_event_o  (event_o.last_event),
    .status_o      (merge_st)
  );

  // A beat that is not the last of its tick leaves more events buffered.
  `BED_ASSERT_IMPLIES(a_not_last_has_more,
    merge_st.out_busy && !event_o.last_event, merge_st.buf_busy)
  // Only multi-click events carry a click count.
  `BED_ASSERT_IMPLIES(a_clicks_only_multi,
    event_o.valid && (event_o.event_kind != EV_MULTI), event_o.click_count == '0)
  // A tick accepted behind a non-final beat would break event order.
  `BED_ASSERT_IMPLIES(a_tick_after_last,
    tick_take && merge_st.out_busy && !event_o.ready, event_o.last_event)

endmodule
